>>> design/lrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrt_pkg;

  localparam int ENTRIES_DEF = 128;

  localparam int COORD_W    = 32;
  localparam int SEED_W     = 64;
  localparam int CAP_W      = 8;
  localparam int SLOT_OUT_W = 7;
  localparam int OCC_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_SEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'b1;

  // item mode
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  // mixing constants for x, y and z
  localparam logic [SEED_W-1:0] MIX_K [3] = '{
    64'h9E37_79B9_7F4A_7C15,
    64'hBF58_476D_1CE4_E5B9,
    64'h1234_5678_9ABC_DEF0
  };

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } coord3_t;

  typedef struct packed {
    logic capture;
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

endpackage

`default_nettype wire

>>> design/lrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lrt_cell #(
  parameter int SLOT_W = 7
) (
  input  wire                     clk_i,
  input  wire lrt_pkg::cell_ctrl_t ctrl_i,
  input  wire lrt_pkg::coord3_t   key_i,
  input  wire                     in_use_i,
  input  wire lrt_pkg::coord3_t   nb_coord_i,
  input  wire        [SLOT_W-1:0] nb_slot_i,
  input  wire        [SLOT_W-1:0] new_slot_i,
  output lrt_pkg::coord3_t        coord_o,
  output logic       [SLOT_W-1:0] slot_o,
  output logic                    match_o
);

  lrt_pkg::coord3_t  coord_q, coord_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              match_q, match_d;

  always_comb begin
    coord_d = coord_q;
    slot_d  = slot_q;
    match_d = match_q;
    if (ctrl_i.capture) begin
      match_d = in_use_i && (coord_q == key_i);
    end
    if (ctrl_i.load) begin
      coord_d = key_i;
      slot_d  = new_slot_i;
    end else if (ctrl_i.shift) begin
      // move one place toward the least recent end
      coord_d = nb_coord_i;
      slot_d  = nb_slot_i;
    end
  end

  always_ff @(posedge clk_i) begin
    coord_q <= coord_d;
    slot_q  <= slot_d;
    match_q <= match_d;
  end

  assign coord_o = coord_q;
  assign slot_o  = slot_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

>>> design/lrt_seed_mix.sv
`timescale 1ns / 1ps
`default_nettype none

module lrt_seed_mix (
  input  wire                                 clk_i,
  input  wire                                 en_i,
  input  wire lrt_pkg::coord3_t               key_i,
  input  wire        [lrt_pkg::SEED_W-1:0]    master_i,
  output logic       [lrt_pkg::SEED_W-1:0]    seed_o
);

  localparam int CW = lrt_pkg::COORD_W;
  localparam int SW = lrt_pkg::SEED_W;

  logic [CW-1:0] coord [3];
  logic [SW-1:0] prod  [3];

  assign coord[0] = key_i.x;
  assign coord[1] = key_i.y;
  assign coord[2] = key_i.z;

  for (genvar k = 0; k < 3; k++) begin : g_mix
    localparam logic [CW-1:0] MLO = lrt_pkg::MIX_K[k][CW-1:0];
    localparam logic [CW-1:0] MHI = lrt_pkg::MIX_K[k][SW-1:CW];

    logic [SW-1:0] lo_q, lo_d;
    logic [CW-1:0] hi_q, hi_d;
    logic          sign_q;
    logic [CW-1:0] upper;

    // sign extension turns into subtracting the low constant half above bit 31
    assign lo_d = SW'(coord[k]) * SW'(MLO);
    assign hi_d = coord[k] * MHI;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_q   <= lo_d;
        hi_q   <= hi_d;
        sign_q <= coord[k][CW-1];
      end
    end

    assign upper   = hi_q - (sign_q ? MLO : '0);
    assign prod[k] = lo_q + {upper, {CW{1'b0}}};
  end

  assign seed_o = master_i ^ prod[0] ^ prod[1] ^ prod[2];

endmodule

`default_nettype wire

>>> design/lru_region_tag_cache_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Fully associative LRU tag store keyed by a signed 3-D coordinate, built as a
// row of ENTRIES cells ordered from least recent (cell 0) to most recent. A
// lookup passes a compare state and then an update state: in the first every
// cell compares its coordinate with the key and registers a match bit while
// the seed multipliers register their partial products; in the second the
// chain shifts by one place behind the removed entry and the new entry is
// written at the tail. The next item is accepted in the update state, not
// before, set by the compare-then-update of the recency chain. A clear item
// empties the store in its update state. Results sit in an output register,
// and the update state waits while that register still holds an unread item.
module lru_region_tag_cache_core #(
  parameter int ENTRIES = lrt_pkg::ENTRIES_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire                                  mode_i,
  input  wire signed [lrt_pkg::COORD_W-1:0]    coord_x_i,
  input  wire signed [lrt_pkg::COORD_W-1:0]    coord_y_i,
  input  wire signed [lrt_pkg::COORD_W-1:0]    coord_z_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic                                 hit_o,
  output logic       [lrt_pkg::SLOT_OUT_W-1:0] slot_o,
  output logic                                 evicted_o,
  output logic signed [lrt_pkg::COORD_W-1:0]   evicted_x_o,
  output logic signed [lrt_pkg::COORD_W-1:0]   evicted_y_o,
  output logic signed [lrt_pkg::COORD_W-1:0]   evicted_z_o,
  output logic       [lrt_pkg::SEED_W-1:0]     region_seed_o,
  output logic       [lrt_pkg::OCC_W-1:0]      occupancy_o,
  input  wire                                  cfg_we_i,
  input  wire        [lrt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire        [lrt_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int SW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > lrt_pkg::CAP_W) ? CW : lrt_pkg::CAP_W;

  lrt_pkg::state_e state_q, state_d;

  logic [lrt_pkg::SEED_W-1:0] master_q;
  logic [lrt_pkg::CAP_W-1:0]  cap_q;
  logic [CW-1:0]              count_q, count_d;

  logic             req_mode_q;
  lrt_pkg::coord3_t req_key_q;

  logic out_free, accept, do_upd;

  // cell row
  lrt_pkg::coord3_t    cell_coord [ENTRIES];
  logic [SW-1:0]       cell_slot  [ENTRIES];
  lrt_pkg::cell_ctrl_t cell_ctrl  [ENTRIES];
  logic [ENTRIES-1:0]  match_vec;
  logic [ENTRIES-1:0]  seen;
  logic [ENTRIES-1:0]  in_use;

  logic                       hit, full, evict, remove;
  logic [SW-1:0]              hit_slot, new_slot;
  logic [CW-1:0]              tail;
  logic [lrt_pkg::CAP_W-1:0]  cap_clip;
  logic [CMPW-1:0]            cap_ext, cap_eff;
  logic [lrt_pkg::SEED_W-1:0] seed;

  // output register
  logic                            out_valid_q;
  logic                            hit_q, evicted_q;
  logic [lrt_pkg::SLOT_OUT_W-1:0]  slot_q;
  logic [lrt_pkg::COORD_W-1:0]     ev_x_q, ev_y_q, ev_z_q;
  logic [lrt_pkg::SEED_W-1:0]      seed_q;
  logic [lrt_pkg::OCC_W-1:0]       occ_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == lrt_pkg::ST_IDLE) || ((state_q == lrt_pkg::ST_UPD) && out_free);
  assign accept     = in_valid_i && in_ready_o;
  assign do_upd     = (state_q == lrt_pkg::ST_UPD) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lrt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lrt_pkg::ST_CMP;
        end
      end
      lrt_pkg::ST_CMP: begin
        state_d = lrt_pkg::ST_UPD;
      end
      lrt_pkg::ST_UPD: begin
        if (out_free) begin
          state_d = accept ? lrt_pkg::ST_CMP : lrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lrt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= '0;
      cap_q    <= lrt_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lrt_pkg::CFG_MASTER_SEED: master_q <= cfg_wdata_i;
        lrt_pkg::CFG_CAPACITY:    cap_q    <= cfg_wdata_i[lrt_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_mode_q  <= mode_i;
      req_key_q.x <= coord_x_i;
      req_key_q.y <= coord_y_i;
      req_key_q.z <= coord_z_i;
    end
  end

  lrt_seed_mix u_seed (
    .clk_i    (clk_i),
    .en_i     (state_q == lrt_pkg::ST_CMP),
    .key_i    (req_key_q),
    .master_i (master_q),
    .seed_o   (seed)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    localparam logic [ENTRIES-1:0] LE_MASK = {ENTRIES{1'b1}} >> (ENTRIES - 1 - i);

    lrt_pkg::coord3_t nb_coord;
    logic [SW-1:0]    nb_slot;

    if (i == ENTRIES - 1) begin : g_last
      assign nb_coord = cell_coord[i];
      assign nb_slot  = cell_slot[i];
    end else begin : g_mid
      assign nb_coord = cell_coord[i+1];
      assign nb_slot  = cell_slot[i+1];
    end

    assign in_use[i] = CW'(i) < count_q;
    // set at and above the matching position
    assign seen[i]   = |(match_vec & LE_MASK);

    assign cell_ctrl[i].capture = (state_q == lrt_pkg::ST_CMP);
    assign cell_ctrl[i].shift   = do_upd && (req_mode_q == lrt_pkg::MODE_LOOKUP) && remove &&
                                  (evict || seen[i]) && (CW'(i) < tail);
    assign cell_ctrl[i].load    = do_upd && (req_mode_q == lrt_pkg::MODE_LOOKUP) &&
                                  (CW'(i) == tail);

    lrt_cell #(
      .SLOT_W (SW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[i]),
      .key_i      (req_key_q),
      .in_use_i   (in_use[i]),
      .nb_coord_i (nb_coord),
      .nb_slot_i  (nb_slot),
      .new_slot_i (new_slot),
      .coord_o    (cell_coord[i]),
      .slot_o     (cell_slot[i]),
      .match_o    (match_vec[i])
    );
  end

  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_slot = hit_slot | (match_vec[i] ? cell_slot[i] : '0);
    end
  end

  always_comb begin
    cap_clip = (cap_q == '0) ? lrt_pkg::CAP_W'(1) : cap_q;
    cap_ext  = CMPW'(cap_clip);
    cap_eff  = (cap_ext > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_ext;

    hit    = |match_vec;
    full   = CMPW'(count_q) >= cap_eff;
    evict  = !hit && full;
    remove = hit || evict;
    tail   = remove ? (count_q - CW'(1)) : count_q;

    if (hit) begin
      new_slot = hit_slot;
    end else if (evict) begin
      new_slot = cell_slot[0];
    end else begin
      new_slot = SW'(count_q);
    end

    if (req_mode_q == lrt_pkg::MODE_CLEAR) begin
      count_d = '0;
    end else begin
      count_d = remove ? count_q : (count_q + CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (do_upd) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_upd) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_upd) begin
      if (req_mode_q == lrt_pkg::MODE_CLEAR) begin
        hit_q     <= 1'b0;
        slot_q    <= '0;
        evicted_q <= 1'b0;
        ev_x_q    <= '0;
        ev_y_q    <= '0;
        ev_z_q    <= '0;
        seed_q    <= '0;
      end else begin
        hit_q     <= hit;
        slot_q    <= lrt_pkg::SLOT_OUT_W'(new_slot);
        evicted_q <= evict;
        ev_x_q    <= evict ? cell_coord[0].x : '0;
        ev_y_q    <= evict ? cell_coord[0].y : '0;
        ev_z_q    <= evict ? cell_coord[0].z : '0;
        seed_q    <= seed;
      end
      occ_q <= lrt_pkg::OCC_W'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign slot_o        = slot_q;
  assign evicted_o     = evicted_q;
  assign evicted_x_o   = ev_x_q;
  assign evicted_y_o   = ev_y_q;
  assign evicted_z_o   = ev_z_q;
  assign region_seed_o = seed_q;
  assign occupancy_o   = occ_q;

endmodule

`default_nettype wire

>>> design/lrt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lrt_checker (
  input wire                                  clk_i,
  input wire                                  rst_ni,
  input wire                                  in_valid_i,
  input wire                                  in_ready_o,
  input wire                                  out_valid_o,
  input wire                                  out_ready_i,
  input wire                                  hit_o,
  input wire       [lrt_pkg::SLOT_OUT_W-1:0]  slot_o,
  input wire                                  evicted_o,
  input wire signed [lrt_pkg::COORD_W-1:0]    evicted_x_o,
  input wire signed [lrt_pkg::COORD_W-1:0]    evicted_y_o,
  input wire signed [lrt_pkg::COORD_W-1:0]    evicted_z_o,
  input wire       [lrt_pkg::SEED_W-1:0]      region_seed_o
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(slot_o) && $stable(region_seed_o))
    else $error("result changed while stalled");

  // one item in flight: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted before the previous lookup finished");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_o)
    else $error("hit reported together with an eviction");

  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_o |-> (evicted_x_o == 0) && (evicted_y_o == 0) &&
                                  (evicted_z_o == 0))
    else $error("evicted coordinate not zero without eviction");

endmodule

bind lru_region_tag_cache_core lrt_checker u_lrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .hit_o         (hit_o),
  .slot_o        (slot_o),
  .evicted_o     (evicted_o),
  .evicted_x_o   (evicted_x_o),
  .evicted_y_o   (evicted_y_o),
  .evicted_z_o   (evicted_z_o),
  .region_seed_o (region_seed_o)
);

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int ENTRIES     = lrt_pkg::ENTRIES_DEF;
  localparam int MAX_WAIT    = 13;
  localparam int CYCLE_LIMIT = 600000;
  localparam int NUM_PHASES  = 9;

  localparam logic [lrt_pkg::SEED_W-1:0] MULT_X = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [lrt_pkg::SEED_W-1:0] MULT_Y = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [lrt_pkg::SEED_W-1:0] MULT_Z = 64'h1234_5678_9ABC_DEF0;

  localparam logic [lrt_pkg::COORD_W-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [lrt_pkg::COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [lrt_pkg::COORD_W-1:0] COORD_NEG = 32'hFFFF_FFFF;

  typedef struct packed {
    logic                           hit;
    logic [lrt_pkg::SLOT_OUT_W-1:0] slot;
    logic                           evicted;
    logic [lrt_pkg::COORD_W-1:0]    ev_x;
    logic [lrt_pkg::COORD_W-1:0]    ev_y;
    logic [lrt_pkg::COORD_W-1:0]    ev_z;
    logic [lrt_pkg::SEED_W-1:0]     seed;
    logic [lrt_pkg::OCC_W-1:0]      occ;
  } lookup_result_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           mode_i      = lrt_pkg::MODE_LOOKUP;
  logic [lrt_pkg::COORD_W-1:0]    coord_x_i   = '0;
  logic [lrt_pkg::COORD_W-1:0]    coord_y_i   = '0;
  logic [lrt_pkg::COORD_W-1:0]    coord_z_i   = '0;
  logic                           out_ready_i = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [lrt_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = lrt_pkg::CFG_MASTER_SEED;
  logic [lrt_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  logic                           in_ready_o;
  logic                           out_valid_o;
  logic                           hit_o;
  logic [lrt_pkg::SLOT_OUT_W-1:0] slot_o;
  logic                           evicted_o;
  logic [lrt_pkg::COORD_W-1:0]    evicted_x_o;
  logic [lrt_pkg::COORD_W-1:0]    evicted_y_o;
  logic [lrt_pkg::COORD_W-1:0]    evicted_z_o;
  logic [lrt_pkg::SEED_W-1:0]     region_seed_o;
  logic [lrt_pkg::OCC_W-1:0]      occupancy_o;

  // shadow copy of the tag store, least recent at position 0
  lrt_pkg::coord3_t           lru_coord [ENTRIES];
  int unsigned                lru_slot  [ENTRIES];
  int                         lru_count    = 0;
  logic [lrt_pkg::SEED_W-1:0] seed_reg     = '0;
  logic [lrt_pkg::CAP_W-1:0]  capacity_reg = lrt_pkg::CAP_RESET;

  lookup_result_t expected_results [$];
  int             mismatch_count = 0;
  int             cycle_count    = 0;
  int             out_stall      = 0;
  logic           no_idle        = 1'b0;

  lru_region_tag_cache_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .slot_o       (slot_o),
    .evicted_o    (evicted_o),
    .evicted_x_o  (evicted_x_o),
    .evicted_y_o  (evicted_y_o),
    .evicted_z_o  (evicted_z_o),
    .region_seed_o(region_seed_o),
    .occupancy_o  (occupancy_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** lru_region_tag_cache_core: FAILED **");
      $finish;
    end
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic int effective_capacity();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > ENTRIES) return ENTRIES;
    return capacity_reg;
  endfunction

  function automatic void drop_position(int p);
    int i;
    for (i = p; i + 1 < lru_count; i++) begin
      lru_coord[i] = lru_coord[i + 1];
      lru_slot[i]  = lru_slot[i + 1];
    end
    lru_count--;
  endfunction

  // advances the shadow store by one item and returns the result it owes
  function automatic lookup_result_t cache_model_lookup(logic m, lrt_pkg::coord3_t key);
    lookup_result_t r;
    int             pos;
    int             i;
    int unsigned    s;
    r   = '0;
    pos = -1;
    if (m == lrt_pkg::MODE_CLEAR) begin
      lru_count = 0;
      return r;
    end
    r.seed = seed_reg ^ ({{32{key.x[31]}}, key.x} * MULT_X)
                      ^ ({{32{key.y[31]}}, key.y} * MULT_Y)
                      ^ ({{32{key.z[31]}}, key.z} * MULT_Z);
    for (i = 0; i < lru_count; i++) begin
      if (pos < 0 && lru_coord[i] == key) pos = i;
    end
    if (pos >= 0) begin
      r.hit = 1'b1;
      s     = lru_slot[pos];
      drop_position(pos);
    end else if (lru_count >= effective_capacity() && lru_count > 0) begin
      r.evicted = 1'b1;
      r.ev_x    = lru_coord[0].x;
      r.ev_y    = lru_coord[0].y;
      r.ev_z    = lru_coord[0].z;
      s         = lru_slot[0];
      drop_position(0);
    end else begin
      s = lru_count;
    end
    if (lru_count < ENTRIES) begin
      lru_coord[lru_count] = key;
      lru_slot[lru_count]  = s;
      lru_count++;
    end
    r.slot = s[lrt_pkg::SLOT_OUT_W-1:0];
    r.occ  = lru_count[lrt_pkg::OCC_W-1:0];
    return r;
  endfunction

  task automatic send_item(input logic m, input logic [lrt_pkg::COORD_W-1:0] x,
                           input logic [lrt_pkg::COORD_W-1:0] y,
                           input logic [lrt_pkg::COORD_W-1:0] z);
    int               gap;
    lrt_pkg::coord3_t key;
    gap = draw_wait();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    coord_x_i  <= x;
    coord_y_i  <= y;
    coord_z_i  <= z;
    do @(posedge clk_i); while (!in_ready_o);
    key.x = x;
    key.y = y;
    key.z = z;
    expected_results.push_back(cache_model_lookup(m, key));
  endtask

  task automatic lookup(input logic [lrt_pkg::COORD_W-1:0] x,
                        input logic [lrt_pkg::COORD_W-1:0] y,
                        input logic [lrt_pkg::COORD_W-1:0] z);
    send_item(lrt_pkg::MODE_LOOKUP, x, y, z);
  endtask

  task automatic clear_store();
    send_item(lrt_pkg::MODE_CLEAR, $urandom, $urandom, $urandom);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // registers only change with the block idle
  task automatic write_reg(input logic [lrt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lrt_pkg::CFG_DATA_W-1:0] data);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == lrt_pkg::CFG_MASTER_SEED) seed_reg = data;
    else capacity_reg = data[lrt_pkg::CAP_W-1:0];
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch in %s at cycle %0d: expected %h, got %h",
                 name, cycle_count, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    lookup_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result with nothing expected at cycle %0d", cycle_count);
      end else begin
        want = expected_results.pop_front();
        check_field("hit", want.hit, hit_o);
        check_field("slot", want.slot, slot_o);
        check_field("evicted", want.evicted, evicted_o);
        check_field("evicted_x", want.ev_x, evicted_x_o);
        check_field("evicted_y", want.ev_y, evicted_y_o);
        check_field("evicted_z", want.ev_z, evicted_z_o);
        check_field("region_seed", want.seed, region_seed_o);
        check_field("occupancy", want.occ, occupancy_o);
      end
      out_stall = draw_wait();
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_stall > 0) begin
        out_stall   = out_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic test_seed_extremes();
    lookup(32'd0, 32'd0, 32'd0);
    lookup(32'd0, 32'd0, 32'd0);
    lookup(COORD_MIN, COORD_MAX, COORD_NEG);
    lookup(COORD_MAX, COORD_MIN, 32'd0);
    lookup(COORD_NEG, COORD_NEG, COORD_NEG);
    write_reg(lrt_pkg::CFG_MASTER_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
    lookup(COORD_MIN, COORD_MIN, COORD_MIN);
    lookup(COORD_MAX, COORD_MAX, COORD_MAX);
    lookup(32'd0, 32'd0, 32'd0);
  endtask

  task automatic test_clear_store();
    clear_store();
    lookup(32'd0, 32'd0, 32'd0);
    clear_store();
    // clear of an already empty store
    clear_store();
  endtask

  task automatic test_capacity_corners();
    // capacity zero acts as one
    write_reg(lrt_pkg::CFG_CAPACITY, 64'd0);
    lookup(32'd5, -32'sd6, 32'd7);
    lookup(-32'sd5, 32'd6, -32'sd7);
    lookup(32'd5, -32'sd6, 32'd7);
    write_reg(lrt_pkg::CFG_CAPACITY, 64'd1);
    lookup(-32'sd5, 32'd6, -32'sd7);
    write_reg(lrt_pkg::CFG_CAPACITY, 64'd128);
    lookup(32'd10, 32'd11, 32'd12);
    lookup(32'd10, 32'd11, 32'd13);
    lookup(32'd10, 32'd14, 32'd12);
    lookup(32'd15, 32'd11, 32'd12);
    // capacity dropped under the occupancy: one eviction per miss
    write_reg(lrt_pkg::CFG_CAPACITY, 64'd2);
    lookup(32'd20, 32'd21, 32'd22);
    lookup(32'd23, 32'd24, 32'd25);
    lookup(32'd10, 32'd14, 32'd12);
    // above the entry count saturates
    write_reg(lrt_pkg::CFG_CAPACITY, 64'd255);
    lookup(32'd10, 32'd11, 32'd13);
    lookup(32'd30, 32'd31, 32'd32);
  endtask

  function automatic logic [lrt_pkg::CAP_W-1:0] phase_capacity(int p);
    case (p)
      0:       return 8'd1;
      1:       return 8'd2;
      2:       return 8'd5;
      3:       return 8'd16;
      4:       return 8'd64;
      5:       return 8'd128;
      6:       return 8'd0;
      7:       return 8'd255;
      default: return 8'd37;
    endcase
  endfunction

  function automatic logic [lrt_pkg::COORD_W-1:0] corner_value();
    case ($urandom_range(0, 3))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return COORD_NEG;
      default: return 32'd0;
    endcase
  endfunction

  task automatic test_random_traffic();
    lrt_pkg::coord3_t               pool [256];
    int                             pool_size;
    int                             eff;
    int                             n_items;
    int                             p;
    int                             k;
    int                             roll;
    logic [lrt_pkg::CFG_DATA_W-1:0] cap_word;
    lrt_pkg::coord3_t               c;
    for (p = 0; p < NUM_PHASES; p++) begin
      // upper data bits are junk for the capacity register
      cap_word          = {$urandom, $urandom};
      cap_word[lrt_pkg::CAP_W-1:0] = phase_capacity(p);
      write_reg(lrt_pkg::CFG_CAPACITY, cap_word);
      write_reg(lrt_pkg::CFG_MASTER_SEED, {$urandom, $urandom});
      eff       = effective_capacity();
      pool_size = eff + $urandom_range(1, eff / 2 + 3);
      // working set a bit larger than capacity, so hits and evictions both occur
      for (k = 0; k < pool_size; k++) begin
        case ($urandom_range(0, 3))
          0: begin
            pool[k].x = $urandom;
            pool[k].y = $urandom;
            pool[k].z = $urandom;
          end
          1: begin
            pool[k].x = $urandom_range(0, 7) - 4;
            pool[k].y = $urandom_range(0, 7) - 4;
            pool[k].z = $urandom_range(0, 7) - 4;
          end
          2: begin
            // near neighbor: differs from the previous entry on one axis
            pool[k] = (k > 0) ? pool[k - 1] : '0;
            case ($urandom_range(0, 2))
              0:       pool[k].x = $urandom;
              1:       pool[k].y = $urandom;
              default: pool[k].z = $urandom;
            endcase
          end
          default: begin
            pool[k].x = corner_value();
            pool[k].y = corner_value();
            pool[k].z = corner_value();
          end
        endcase
      end
      n_items = 120 + 2 * eff;
      for (k = 0; k < n_items; k++) begin
        if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          clear_store();
        end else if (roll < 12) begin
          lookup($urandom, $urandom, $urandom);
        end else begin
          c = pool[$urandom_range(0, pool_size - 1)];
          lookup(c.x, c.y, c.z);
        end
        if ($urandom_range(0, 79) == 0) drain_results();
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_seed_extremes();
    test_clear_store();
    test_capacity_corners();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("** lru_region_tag_cache_core: PASSED **");
    end else begin
      $display("** lru_region_tag_cache_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> lru_region_tag_cache_core.f
design/lrt_pkg.sv
design/lrt_cell.sv
design/lrt_seed_mix.sv
design/lru_region_tag_cache_core.sv
design/lrt_checker.sv
verif/testbench.sv
